// File: sv/kse_pkg.sv
// package: sizes, payload structs, state codes and helpers for the spanning edge lister
package kse_pkg;

    localparam int MAX_ROOMS  = 8;
    localparam int DIST_BITS  = 16;
    localparam int ROOM_FIELD_BITS = 3;
    localparam int DIST_FIELD_BITS = 16;

    localparam int ROOM_BITS  = (MAX_ROOMS > 2) ? $clog2(MAX_ROOMS) : 1;
    localparam int COUNT_BITS = $clog2(MAX_ROOMS + 1);
    localparam int PAIR_COUNT = MAX_ROOMS * (MAX_ROOMS - 1) / 2;
    localparam int PAIR_BITS  = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

    typedef logic [ROOM_BITS-1:0]  room_t;
    typedef logic [COUNT_BITS-1:0] room_count_t;
    typedef logic [PAIR_BITS-1:0]  pair_idx_t;
    typedef logic [DIST_BITS-1:0]  dist_t;

    typedef struct packed {
        logic [ROOM_FIELD_BITS-1:0] room_a;
        logic [ROOM_FIELD_BITS-1:0] room_b;
        logic [DIST_FIELD_BITS-1:0] distance;
        logic                       final_pair;
    } pair_in_t;

    typedef struct packed {
        logic [ROOM_FIELD_BITS-1:0] edge_high;
        logic [ROOM_FIELD_BITS-1:0] edge_low;
        logic                       last_edge;
    } edge_out_t;

    typedef struct packed {
        logic        clear;
        logic        latch_a;
        logic        merge;
        room_count_t room_count;
        room_t       room_a;
        room_t       room_b;
    } comp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_MERGE,
        ST_EMIT
    } kse_state_t;

    // index of the first pair whose larger room is a: a*(a-1)/2
    function automatic pair_idx_t pair_base(input room_t a);
        logic [2*ROOM_BITS-1:0] prod;
        prod = (2*ROOM_BITS)'(a) * (2*ROOM_BITS)'(a - 1'b1);
        return PAIR_BITS'(prod >> 1);
    endfunction

endpackage

// File: sv/kse_components.sv
// component labels of the rooms: clear, union by relabeling, all-joined flag
module kse_components import kse_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  comp_cmd_t cmd,
    output logic      joined
);

    room_t       label_reg [MAX_ROOMS];
    room_t       la_reg;
    room_count_t count_reg;
    room_t       lb;

    assign lb = label_reg[cmd.room_b];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ROOMS; i++) begin
                label_reg[i] <= ROOM_BITS'(i);
            end
            count_reg <= '0;
        end else if (cmd.clear) begin
            for (int i = 0; i < MAX_ROOMS; i++) begin
                label_reg[i] <= ROOM_BITS'(i);
            end
            count_reg <= cmd.room_count;
        end else if (cmd.merge && (la_reg != lb)) begin
            for (int i = 0; i < MAX_ROOMS; i++) begin
                if (label_reg[i] == lb) begin
                    label_reg[i] <= la_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_a) begin
            la_reg <= label_reg[cmd.room_a];
        end
    end

    always_comb begin
        joined = 1'b1;
        for (int i = 0; i < MAX_ROOMS; i++) begin
            if ((COUNT_BITS'(i) < count_reg) && (label_reg[i] != label_reg[0])) begin
                joined = 1'b0;
            end
        end
    end

endmodule

// File: sv/kruskal_spanning_edge_lister_core.sv
// top level: pair distance memory, minimum scan and result register
// each result after the final pair needs a full scan, with one memory read per pair,
// P = rooms*(rooms-1)/2 reads, followed by the drain, pick, merge and emit states,
// plus any output stall
// throughput: one input transfer per cycle while idle; results one per scan
// reset: clears control, labels and visited flags; distances stay unknown until written
module kruskal_spanning_edge_lister_core import kse_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pair_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output edge_out_t m_payload
);

    kse_state_t state_reg, state_next;

    dist_t pair_mem [PAIR_COUNT];
    dist_t rdata_reg;

    pair_idx_t k_reg, k_next;
    pair_idx_t last_k_reg, last_k_next;
    room_t     pa_reg, pa_next;
    room_t     pb_reg, pb_next;

    logic      cmp_valid_reg;
    pair_idx_t cmp_k_reg;
    room_t     cmp_a_reg, cmp_b_reg;

    logic      found_reg;
    dist_t     best_dist_reg;
    pair_idx_t best_k_reg;
    room_t     best_a_reg, best_b_reg;

    logic [PAIR_COUNT-1:0] used_reg;

    logic      m_valid_reg;
    edge_out_t m_payload_reg;

    logic      accept;
    logic      room_ok;
    room_t     in_a, in_b;
    logic      wr_en;
    pair_idx_t wr_addr;
    logic      start;
    logic      issue;
    logic      load_out;
    logic      joined;
    comp_cmd_t cmd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign room_ok   = int'(s_payload.room_a) < MAX_ROOMS;
    assign in_a      = ROOM_BITS'(s_payload.room_a);
    assign in_b      = ROOM_BITS'(s_payload.room_b);
    assign wr_en     = accept && room_ok && (s_payload.room_b < s_payload.room_a);
    assign wr_addr   = pair_base(in_a) + PAIR_BITS'(in_b);
    assign start     = accept && room_ok && s_payload.final_pair && (s_payload.room_a != '0);
    assign issue     = (state_reg == ST_SCAN);
    assign load_out  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        cmd            = '0;
        cmd.clear      = start;
        cmd.latch_a    = (state_reg == ST_PICK);
        cmd.merge      = (state_reg == ST_MERGE);
        cmd.room_count = COUNT_BITS'(in_a) + 1'b1;
        cmd.room_a     = best_a_reg;
        cmd.room_b     = best_b_reg;
    end

    kse_components u_components (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .joined  (joined)
    );

    // distance memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pair_mem[wr_addr] <= DIST_BITS'(s_payload.distance);
        end
        rdata_reg <= pair_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            last_k_reg <= '0;
            pa_reg     <= '0;
            pb_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            last_k_reg <= last_k_next;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        last_k_next = last_k_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next  = ST_SCAN;
                    last_k_next = pair_base(in_a) + PAIR_BITS'(in_a) - 1'b1;
                    k_next      = '0;
                    pa_next     = ROOM_BITS'(1);
                    pb_next     = '0;
                end
            end
            ST_SCAN: begin
                k_next = k_reg + 1'b1;
                if (pb_reg + 1'b1 == pa_reg) begin
                    pa_next = pa_reg + 1'b1;
                    pb_next = '0;
                end else begin
                    pb_next = pb_reg + 1'b1;
                end
                if (k_reg == last_k_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                state_next = found_reg ? ST_MERGE : ST_IDLE;
            end
            ST_MERGE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (load_out) begin
                    if (joined) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                        k_next     = '0;
                        pa_next    = ROOM_BITS'(1);
                        pb_next    = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // compare stage works on the registered memory read data in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            cmp_valid_reg <= issue;
            if (issue && (k_reg == '0)) begin
                found_reg <= 1'b0;
            end else if (cmp_valid_reg && !used_reg[cmp_k_reg]
                         && (!found_reg || (rdata_reg < best_dist_reg))) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_k_reg <= k_reg;
        cmp_a_reg <= pa_reg;
        cmp_b_reg <= pb_reg;
        if (cmp_valid_reg && !used_reg[cmp_k_reg]
            && (!found_reg || (rdata_reg < best_dist_reg))) begin
            best_dist_reg <= rdata_reg;
            best_k_reg    <= cmp_k_reg;
            best_a_reg    <= cmp_a_reg;
            best_b_reg    <= cmp_b_reg;
        end
    end

    // visited flags
    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            used_reg <= '0;
        end else if ((state_reg == ST_PICK) && found_reg) begin
            used_reg[best_k_reg] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_payload_reg.edge_high <= ROOM_FIELD_BITS'(best_a_reg);
            m_payload_reg.edge_low  <= ROOM_FIELD_BITS'(best_b_reg);
            m_payload_reg.last_edge <= joined;
        end
    end

endmodule

// File: bench/kruskal_spanning_edge_lister_core_tb.sv
// testbench: random room sets against a spanning edge order predictor
`timescale 1ns / 1ps

module kruskal_spanning_edge_lister_core_tb;
    import kse_pkg::*;

    localparam int unsigned ITEM_TARGET = 220;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned IDLE_PCT    = 38;

    typedef enum int unsigned {
        SPREAD_WIDE,
        SPREAD_TIES,
        SPREAD_EXTREME
    } dist_spread_t;

    class spanning_edge_board_t;
        dist_t       pair_dist [PAIR_COUNT];
        edge_out_t   pending_edges [$];
        int unsigned mismatch_count = 0;

        function void take_pair(pair_in_t item);
            int unsigned a, b, rooms, pairs, k, pa, pb, best, best_a, best_b, joins, old_grp;
            bit          found;
            bit          visited [PAIR_COUNT];
            int unsigned grp [MAX_ROOMS];
            edge_out_t   e;
            a = item.room_a;
            b = item.room_b;
            if (a >= MAX_ROOMS) return;
            if (b < a) pair_dist[a * (a - 1) / 2 + b] = item.distance[DIST_BITS-1:0];
            if (!item.final_pair) return;
            rooms = a + 1;
            pairs = rooms * (rooms - 1) / 2;
            for (k = 0; k < MAX_ROOMS; k++) grp[k] = k;
            for (k = 0; k < PAIR_COUNT; k++) visited[k] = 1'b0;
            joins = 0;
            best = 0;
            best_a = 0;
            best_b = 0;
            while (joins + 1 < rooms) begin
                found = 1'b0;
                pa = 1;
                pb = 0;
                for (k = 0; k < pairs; k++) begin
                    if (!visited[k] && (!found || pair_dist[k] < pair_dist[best])) begin
                        best = k;
                        best_a = pa;
                        best_b = pb;
                        found = 1'b1;
                    end
                    pb++;
                    if (pb == pa) begin
                        pa++;
                        pb = 0;
                    end
                end
                if (!found) break;
                visited[best] = 1'b1;
                if (grp[best_a] != grp[best_b]) begin
                    old_grp = grp[best_b];
                    for (k = 0; k < MAX_ROOMS; k++) begin
                        if (grp[k] == old_grp) grp[k] = grp[best_a];
                    end
                    joins++;
                end
                e.edge_high = ROOM_FIELD_BITS'(best_a);
                e.edge_low  = ROOM_FIELD_BITS'(best_b);
                e.last_edge = (joins + 1 >= rooms);
                pending_edges = {pending_edges, e};
            end
        endfunction

        function void check_edge(edge_out_t got);
            edge_out_t want;
            if (pending_edges.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected edge: got %0d-%0d last %0b",
                             got.edge_high, got.edge_low, got.last_edge);
                return;
            end
            want = pending_edges.pop_front();
            if (got.edge_high !== want.edge_high || got.edge_low !== want.edge_low ||
                got.last_edge !== want.last_edge) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("edge mismatch: expected %0d-%0d last %0b, got %0d-%0d last %0b",
                             want.edge_high, want.edge_low, want.last_edge,
                             got.edge_high, got.edge_low, got.last_edge);
            end
        endfunction

        function int unsigned pending();
            return pending_edges.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pair_in_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    edge_out_t m_payload;

    spanning_edge_board_t board = new;
    int unsigned          pairs_sent = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          covered_top = 0;
    logic                 no_idle = 1'b0;

    kruskal_spanning_edge_lister_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [DIST_FIELD_BITS-1:0] pick_distance(input dist_spread_t spread);
        case (spread)
            SPREAD_WIDE: return DIST_FIELD_BITS'($urandom);
            SPREAD_TIES: return DIST_FIELD_BITS'($urandom_range(0, 3));
            default:     return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_pair(input int unsigned a, input int unsigned b,
                             input logic [DIST_FIELD_BITS-1:0] dist_val, input bit fin);
        pair_in_t item;
        item.room_a     = ROOM_FIELD_BITS'(a);
        item.room_b     = ROOM_FIELD_BITS'(b);
        item.distance   = dist_val;
        item.final_pair = fin;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_pair(item);
        if (b < a || fin) pairs_sent++;
        no_idle <= (pairs_sent >= 100 && pairs_sent < 150);
    endtask

    task automatic send_noise();
        send_pair($urandom_range(0, 7), $urandom_range(0, 7), pick_distance(SPREAD_WIDE), 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // shuffled writes of every pair of the first rooms; the last pair or one more starts
    task automatic send_room_set(input int unsigned rooms, input dist_spread_t spread);
        int unsigned pa [PAIR_COUNT];
        int unsigned pb [PAIR_COUNT];
        int unsigned cnt, i, j, t;
        bit          own_final;
        cnt = 0;
        for (i = 1; i < rooms; i++) begin
            for (j = 0; j < i; j++) begin
                pa[cnt] = i;
                pb[cnt] = j;
                cnt++;
            end
        end
        for (i = cnt - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pa[i]; pa[i] = pa[j]; pa[j] = t;
            t = pb[i]; pb[i] = pb[j]; pb[j] = t;
        end
        own_final = $urandom_range(0, 1);
        if (own_final) begin
            j = 0;
            for (i = 0; i < cnt; i++) begin
                if (pa[i] == rooms - 1) j = i;
            end
            t = pa[cnt-1]; pa[cnt-1] = pa[j]; pa[j] = t;
            t = pb[cnt-1]; pb[cnt-1] = pb[j]; pb[j] = t;
        end
        for (i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            send_pair(pa[i], pb[i], pick_distance(spread), own_final && i == cnt - 1);
        end
        if (!own_final)
            send_pair(rooms - 1, $urandom_range(rooms - 1, 7), pick_distance(spread), 1'b1);
        if (rooms - 1 > covered_top) covered_top = rooms - 1;
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_edge(m_payload);
            if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready)))
                quiet_cycles++;
            else
                quiet_cycles = 0;
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned pick, a;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // two rooms, largest distance
        send_pair(1, 0, 16'hFFFF, 1'b1);
        // three rooms with tied distances, started by a misordered transfer
        send_pair(2, 0, 16'h0000, 1'b0);
        send_pair(2, 1, 16'h0000, 1'b0);
        send_pair(2, 7, 16'h5555, 1'b1);
        covered_top = 2;
        // single room
        send_pair(0, 0, 16'h0000, 1'b1);
        send_pair(0, 6, 16'hFFFF, 1'b1);
        // misordered transfers store nothing; the pair 7-6 is stored
        send_pair(7, 7, 16'hAAAA, 1'b0);
        send_pair(3, 5, 16'h1234, 1'b0);
        send_pair(7, 6, 16'hFFFF, 1'b0);
        // four rooms with a rewritten pair
        send_pair(3, 0, 16'hFFFF, 1'b0);
        send_pair(3, 1, 16'hFFFE, 1'b0);
        send_pair(3, 2, 16'h0000, 1'b0);
        send_pair(3, 2, 16'h0001, 1'b1);
        covered_top = 3;
        // rerun over stored distances, with pair 2-1 rewritten
        send_pair(2, 1, 16'hFFFF, 1'b1);
        wait_drained();

        while (pairs_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                send_room_set($urandom_range(2, MAX_ROOMS), dist_spread_t'($urandom_range(0, 2)));
            end else if (pick < 17) begin
                send_noise();
            end else if (pick < 19) begin
                a = $urandom_range(0, covered_top);
                send_pair(a, $urandom_range(0, 7), pick_distance(SPREAD_WIDE), 1'b1);
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
